// ----- rtl/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared constants, command codes and handshake structures.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

	localparam int PATTERN_CAPACITY = 32;
	localparam int LEN_W = $clog2(PATTERN_CAPACITY + 1);

	localparam logic [7:0] ANY_ONE = 8'h3F;
	localparam logic [7:0] ANY_RUN = 8'h2A;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_SUBJECT = 2'd2,
		CMD_END     = 2'd3
	} gwm_cmd_t;

	typedef struct packed {
		logic       accept;
		gwm_cmd_t   cmd;
		logic [7:0] ch;
	} gwm_ctrl_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} gwm_result_t;

endpackage

`default_nettype wire

// ----- rtl/gwm_cell.sv -----
// ----------------------------------------------------------------------------
// Glob wildcard matcher cell
// Holds one pattern byte and the active bit of its pattern position.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gwm_pkg::gwm_ctrl_t ctrl,
	input  wire logic              first,
	input  wire logic              wr_en,
	input  wire logic              fwd_in,
	input  wire logic              carry_in,
	output logic                   fwd_out,
	output logic                   carry_out,
	output logic                   active,
	output logic                   valid
);

	logic [7:0] byte_q;
	logic       valid_q;
	logic       active_q;
	logic [7:0] byte_nx;
	logic       valid_nx;
	logic       star_cur;
	logic       star_nx;
	logic       raw;
	logic       closed;

	always_comb begin
		byte_nx  = wr_en ? ctrl.ch : byte_q;
		valid_nx = valid_q;
		if (ctrl.accept && ctrl.cmd == gwm_pkg::CMD_CLEAR) begin
			valid_nx = 1'b0;
		end else if (wr_en) begin
			valid_nx = 1'b1;
		end
		star_cur = valid_q && (byte_q == gwm_pkg::ANY_RUN);
		star_nx  = valid_nx && (byte_nx == gwm_pkg::ANY_RUN);
		raw      = first;
		if (ctrl.accept && ctrl.cmd == gwm_pkg::CMD_SUBJECT) begin
			raw = fwd_in | (active_q & star_cur);
		end
		closed    = raw | carry_in;
		carry_out = closed & star_nx;
		fwd_out   = active_q & valid_q & ~star_cur &
			((byte_q == gwm_pkg::ANY_ONE) || (byte_q == ctrl.ch));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= first;
		end else if (ctrl.accept) begin
			valid_q  <= valid_nx;
			active_q <= closed;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_q <= ctrl.ch;
		end
	end

	assign active = active_q;
	assign valid  = valid_q;

endmodule

`default_nettype wire

// ----- rtl/gwm_out_buf.sv -----
// ----------------------------------------------------------------------------
// Glob wildcard matcher result buffer
// Two-entry queue that holds results until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire gwm_pkg::gwm_result_t d,
	output logic                     full,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output gwm_pkg::gwm_result_t     q
);

	gwm_pkg::gwm_result_t head_q;
	gwm_pkg::gwm_result_t tail_q;
	logic [1:0]           count_q;
	logic                 pop;

	assign pop       = (count_q != 2'd0) && out_ready;
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign q         = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				head_q <= d;
			end else begin
				tail_q <= d;
			end
		end else if (push && pop) begin
			if (count_q == 2'd1) begin
				head_q <= d;
			end else begin
				head_q <= tail_q;
				tail_q <= d;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("result pushed into full buffer");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd1 && pop && !push |=> !out_valid)
		else $error("buffer did not drain");

endmodule

`default_nettype wire

// ----- rtl/glob_wildcard_matcher.sv -----
// A result enters the output buffer register when its end-of-subject command is accepted.
// Throughput: one item per cycle; the row of pattern cells updates the whole active set at once.
// Input stalls only when two results wait in the output buffer.
// Reset empties the pattern, clears the overflow flag and leaves only position zero active.
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Streams subject bytes through a row of pattern cells that track active positions.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] char_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            matched,
	output logic            pattern_overflow
);

	localparam int CAP = gwm_pkg::PATTERN_CAPACITY;
	localparam int LW  = gwm_pkg::LEN_W;

	gwm_pkg::gwm_ctrl_t   ctrl;
	gwm_pkg::gwm_result_t res;
	gwm_pkg::gwm_result_t res_out;
	logic                 full;
	logic [LW-1:0]        len_q;
	logic                 overflow_q;
	logic                 end_q;
	logic                 end_closed;
	logic [CAP-1:0]       fwd;
	logic [CAP-1:0]       carry;
	logic [CAP-1:0]       act;
	logic [CAP-1:0]       vld;
	logic [CAP-1:0]       wr_en;
	logic [CAP:0]         active_vec;
	logic                 push;

	assign in_ready    = !full;
	assign ctrl.accept = in_valid && in_ready;
	assign ctrl.cmd    = gwm_pkg::gwm_cmd_t'(command);
	assign ctrl.ch     = char_value;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic fwd_in;
		logic carry_in;
		if (i == 0) begin : g_head
			assign fwd_in   = 1'b0;
			assign carry_in = 1'b0;
		end else begin : g_body
			assign fwd_in   = fwd[i-1];
			assign carry_in = carry[i-1];
		end
		assign wr_en[i] = ctrl.accept && (ctrl.cmd == gwm_pkg::CMD_APPEND) &&
			(len_q == LW'(i));
		gwm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.first    ((i == 0) ? 1'b1 : 1'b0),
			.wr_en    (wr_en[i]),
			.fwd_in   (fwd_in),
			.carry_in (carry_in),
			.fwd_out  (fwd[i]),
			.carry_out(carry[i]),
			.active   (act[i]),
			.valid    (vld[i])
		);
	end

	assign end_closed = ((ctrl.cmd == gwm_pkg::CMD_SUBJECT) ? fwd[CAP-1] : 1'b0) |
		carry[CAP-1];
	assign active_vec = {end_q, act};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
			end_q      <= 1'b0;
		end else if (ctrl.accept) begin
			end_q <= end_closed;
			unique case (ctrl.cmd)
				gwm_pkg::CMD_CLEAR: begin
					len_q      <= '0;
					overflow_q <= 1'b0;
				end
				gwm_pkg::CMD_APPEND: begin
					if (len_q < LW'(CAP)) begin
						len_q <= len_q + LW'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end
				gwm_pkg::CMD_SUBJECT, gwm_pkg::CMD_END: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign push         = ctrl.accept && (ctrl.cmd == gwm_pkg::CMD_END);
	assign res.matched  = active_vec[len_q];
	assign res.overflow = overflow_q;

	gwm_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.d        (res),
		.full     (full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.q        (res_out)
	);

	assign matched          = res_out.matched;
	assign pattern_overflow = res_out.overflow;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAP))
		else $error("pattern length beyond capacity");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) == int'(len_q))
		else $error("cell valid bits disagree with pattern length");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept && ctrl.cmd == gwm_pkg::CMD_CLEAR |=>
		len_q == '0 && !overflow_q && active_vec == (CAP+1)'(1))
		else $error("clear did not restart the matcher");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("end of subject gave no result");

endmodule

`default_nettype wire

// ----- verif/glob_wildcard_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// Glob wildcard matcher testbench
// Streams pattern and subject commands through the matcher with random
// stalls on both sides and checks every end-of-subject result against a
// predictor that tracks the active pattern positions of the subject.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_tb;

	import gwm_pkg::*;

	localparam int ITEM_TARGET = 750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		gwm_cmd_t   cmd;
		logic [7:0] ch;
	} match_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = CMD_CLEAR;
	logic [7:0] char_value = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	logic [7:0]                pat_bytes [PATTERN_CAPACITY];
	int                        pat_len;
	logic [PATTERN_CAPACITY:0] live_positions;
	logic                      pat_overflowed;

	match_cmd_t  pending_cmds[$];
	gwm_result_t expected_verdicts[$];

	int send_idle = 0;
	int recv_idle = 0;
	int total_cmds = 0;
	int cmds_accepted = 0;
	int verdicts_seen = 0;
	int match_count = 0;
	int overflow_count = 0;
	int error_count = 0;
	int cycle_count = 0;

	glob_wildcard_matcher dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.char_value      (char_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.matched         (matched),
		.pattern_overflow(pattern_overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [PATTERN_CAPACITY:0] close_over_runs(
		input logic [PATTERN_CAPACITY:0] positions
	);
		for (int i = 0; i < pat_len; i++) begin
			if (positions[i] && pat_bytes[i] == ANY_RUN)
				positions[i + 1] = 1'b1;
		end
		return positions;
	endfunction

	task automatic track_command(input gwm_cmd_t cmd, input logic [7:0] ch);
		logic [PATTERN_CAPACITY:0] next_positions;
		gwm_result_t               verdict;
		case (cmd)
			CMD_CLEAR: begin
				pat_len = 0;
				pat_overflowed = 1'b0;
				live_positions = close_over_runs((PATTERN_CAPACITY + 1)'(1));
			end
			CMD_APPEND: begin
				if (pat_len < PATTERN_CAPACITY) begin
					pat_bytes[pat_len] = ch;
					pat_len++;
				end else begin
					pat_overflowed = 1'b1;
				end
				live_positions = close_over_runs((PATTERN_CAPACITY + 1)'(1));
			end
			CMD_SUBJECT: begin
				next_positions = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (live_positions[i]) begin
						if (pat_bytes[i] == ANY_RUN)
							next_positions[i] = 1'b1;
						else if (pat_bytes[i] == ANY_ONE || pat_bytes[i] == ch)
							next_positions[i + 1] = 1'b1;
					end
				end
				live_positions = close_over_runs(next_positions);
			end
			default: begin
				verdict.matched = live_positions[pat_len];
				verdict.overflow = pat_overflowed;
				expected_verdicts.push_back(verdict);
				live_positions = close_over_runs((PATTERN_CAPACITY + 1)'(1));
			end
		endcase
	endtask

	task automatic queue_cmd(input gwm_cmd_t cmd, input logic [7:0] ch);
		match_cmd_t item;
		item.cmd = cmd;
		item.ch = ch;
		pending_cmds.push_back(item);
	endtask

	function automatic logic [7:0] letter_byte();
		return $urandom_range(1) ? "a" : "b";
	endfunction

	function automatic logic [7:0] glob_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return letter_byte();
		else if (pick < 70)
			return ANY_ONE;
		else if (pick < 85)
			return ANY_RUN;
		return 8'($urandom_range(255));
	endfunction

	// A pattern followed by subjects drawn from it, some of them corrupted.
	task automatic queue_glob_session();
		logic [7:0] pat[$];
		logic [7:0] subj[$];
		int         len;
		int         idx;
		if ($urandom_range(99) < 85)
			queue_cmd(CMD_CLEAR, 8'($urandom_range(255)));
		len = ($urandom_range(99) < 5) ? $urandom_range(28, 36) : $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			pat.push_back(glob_byte());
			queue_cmd(CMD_APPEND, pat[i]);
		end
		repeat ($urandom_range(1, 3)) begin
			subj.delete();
			foreach (pat[i]) begin
				if (pat[i] == ANY_RUN) begin
					repeat ($urandom_range(0, 3))
						subj.push_back(letter_byte());
				end else if (pat[i] == ANY_ONE) begin
					subj.push_back(8'($urandom_range(255)));
				end else begin
					subj.push_back(pat[i]);
				end
			end
			if ($urandom_range(99) < 35) begin
				idx = (subj.size() > 0) ? $urandom_range(subj.size() - 1) : 0;
				case ($urandom_range(2))
					0: if (subj.size() > 0) subj[idx] = glob_byte();
					1: if (subj.size() > 0) subj.delete(idx);
					default: subj.insert(idx, glob_byte());
				endcase
			end
			foreach (subj[i]) begin
				if ($urandom_range(99) < 2)
					queue_cmd(CMD_APPEND, glob_byte());
				queue_cmd(CMD_SUBJECT, subj[i]);
			end
			queue_cmd(CMD_END, 8'($urandom_range(255)));
		end
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 6))
			queue_cmd(gwm_cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
	endtask

	always @(posedge clk) begin : drive_cmds
		match_cmd_t item;
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
				item = pending_cmds.pop_front();
				in_valid <= 1'b1;
				command <= item.cmd;
				char_value <= item.ch;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : observe
		gwm_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_command(gwm_cmd_t'(command), char_value);
				cmds_accepted++;
			end
			if (out_valid && out_ready) begin
				verdicts_seen++;
				if (matched)
					match_count++;
				if (pattern_overflow)
					overflow_count++;
				if (expected_verdicts.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual matched=%0b overflow=%0b",
						$time, matched, pattern_overflow);
				end else begin
					want = expected_verdicts.pop_front();
					if (matched !== want.matched) begin
						error_count++;
						$display("%0t: matched mismatch, expected %0b, actual %0b",
							$time, want.matched, matched);
					end
					if (pattern_overflow !== want.overflow) begin
						error_count++;
						$display("%0t: pattern_overflow mismatch, expected %0b, actual %0b",
							$time, want.overflow, pattern_overflow);
					end
				end
			end
		end
	end

	initial begin
		pat_len = 0;
		pat_overflowed = 1'b0;
		live_positions = (PATTERN_CAPACITY + 1)'(1);

		// Empty pattern against the empty subject, then against one byte.
		queue_cmd(CMD_END, 8'hAA);
		queue_cmd(CMD_SUBJECT, "a");
		queue_cmd(CMD_END, 8'h00);
		// A zero byte in the pattern and the subject is an ordinary literal.
		queue_cmd(CMD_APPEND, "a");
		queue_cmd(CMD_APPEND, ANY_RUN);
		queue_cmd(CMD_APPEND, 8'h00);
		queue_cmd(CMD_APPEND, ANY_ONE);
		queue_cmd(CMD_SUBJECT, "a");
		queue_cmd(CMD_SUBJECT, 8'h00);
		queue_cmd(CMD_SUBJECT, 8'hFF);
		queue_cmd(CMD_END, 8'hFF);
		queue_cmd(CMD_SUBJECT, "a");
		queue_cmd(CMD_SUBJECT, "x");
		queue_cmd(CMD_SUBJECT, 8'h00);
		queue_cmd(CMD_SUBJECT, ANY_ONE);
		queue_cmd(CMD_END, 8'h55);
		// An append in the middle of a subject restarts it.
		queue_cmd(CMD_SUBJECT, "a");
		queue_cmd(CMD_SUBJECT, 8'h00);
		queue_cmd(CMD_APPEND, ANY_RUN);
		queue_cmd(CMD_END, 8'h00);
		// A leading star is active before any subject byte.
		queue_cmd(CMD_CLEAR, 8'hFF);
		queue_cmd(CMD_APPEND, ANY_RUN);
		queue_cmd(CMD_END, 8'h00);

		while (pending_cmds.size() < ITEM_TARGET + 23) begin
			if ($urandom_range(99) < 80)
				queue_glob_session();
			else
				queue_noise();
		end
		total_cmds = pending_cmds.size();

		send_idle = 37;
		recv_idle = 58;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (cmds_accepted < total_cmds / 3) @(posedge clk);
		send_idle = 58;
		recv_idle = 37;
		while (cmds_accepted < 2 * total_cmds / 3) @(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		while (cmds_accepted < total_cmds) @(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands under three stall mixes; checked %0d end-of-subject results.",
			cmds_accepted, verdicts_seen);
		$display("Results with a match: %0d, with a dropped pattern byte: %0d, errors: %0d.",
			match_count, overflow_count, error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/gwm_pkg.sv
rtl/gwm_cell.sv
rtl/gwm_out_buf.sv
rtl/glob_wildcard_matcher.sv
verif/glob_wildcard_matcher_tb.sv
